// ===== rtl/bar_pkg.sv =====
// Shared constants for the button auto-repeat block: pad bit masks,
// register indexes and reset values. No dependencies.
`default_nettype none

package bar_pkg;

	localparam int unsigned COUNT_BITS_DEF = 16;
	localparam int unsigned PAD_W          = 32;
	localparam int unsigned CFG_W          = 16;
	localparam int unsigned CFG_IDX_W      = 2;

	localparam logic [PAD_W-1:0] BTN_L1     = 32'h0000_0004;
	localparam logic [PAD_W-1:0] BTN_R1     = 32'h0000_0008;
	localparam logic [PAD_W-1:0] BTN_SQUARE = 32'h0000_0080;
	localparam logic [PAD_W-1:0] BTN_UP     = 32'h0000_1000;
	localparam logic [PAD_W-1:0] BTN_RIGHT  = 32'h0000_2000;
	localparam logic [PAD_W-1:0] BTN_DOWN   = 32'h0000_4000;
	localparam logic [PAD_W-1:0] BTN_LEFT   = 32'h0000_8000;
	localparam logic [PAD_W-1:0] BTN_DPAD   = BTN_UP | BTN_RIGHT | BTN_DOWN | BTN_LEFT;
	localparam logic [PAD_W-1:0] BTN_SHLD   = BTN_L1 | BTN_R1;
	localparam logic [PAD_W-1:0] BTN_UPDOWN = 32'h0000_5000;
	localparam logic [PAD_W-1:0] BTN_LR     = BTN_RIGHT | BTN_LEFT;
	localparam logic [PAD_W-1:0] BTN_RPT    = BTN_SHLD | BTN_DPAD;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INIT_DELAY = 2'd0,
		REG_RPT_PERIOD = 2'd1,
		REG_SEC_PERIOD = 2'd2
	} cfg_reg_t;

	localparam logic [CFG_W-1:0] INIT_DELAY_RST = 16'd20;
	localparam logic [CFG_W-1:0] RPT_PERIOD_RST = 16'd4;
	localparam logic [CFG_W-1:0] SEC_PERIOD_RST = 16'd8;

endpackage

`default_nettype wire

// ===== rtl/button_auto_repeat.sv =====
// Pad auto-repeat: edge detect plus typematic repeat of held shoulder
// and d-pad buttons, one pad sample per beat. Depends on bar_pkg.
//
//  channel | handshake             | payload
//  in      | in_valid / in_stall   | pad_bits, counters_hold
//  out     | out_valid / out_stall | new_press, held_now, held_before
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One beat per cycle sustained while out_stall is low; a beat passes the input
// register, then the compare and saturating-increment logic into the result register.
// The sample history and counters update as a beat moves into the result
// register. Reset clears history, counters and loads register defaults.
// A stalled result holds the result register; the input register fills
// behind it, then in_stall rises.
`default_nettype none

module button_auto_repeat #(
	parameter int unsigned COUNT_BITS = bar_pkg::COUNT_BITS_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire  [bar_pkg::PAD_W-1:0]     pad_bits,
	input  wire                           counters_hold,
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic [bar_pkg::PAD_W-1:0]     new_press,
	output logic [bar_pkg::PAD_W-1:0]     held_now,
	output logic [bar_pkg::PAD_W-1:0]     held_before,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire  [bar_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [bar_pkg::CFG_W-1:0]     cfg_data
);

	localparam int unsigned CMP_W = (COUNT_BITS > bar_pkg::CFG_W) ? COUNT_BITS : bar_pkg::CFG_W;

	logic [bar_pkg::CFG_W-1:0] init_delay_q;
	logic [bar_pkg::CFG_W-1:0] rpt_period_q;
	logic [bar_pkg::CFG_W-1:0] sec_period_q;

	logic                      valid_s1;
	logic [bar_pkg::PAD_W-1:0] pad_s1;
	logic                      hold_s1;

	logic [bar_pkg::PAD_W-1:0] last_q;
	logic [COUNT_BITS-1:0]     hold_cnt_q;
	logic [COUNT_BITS-1:0]     rpt_cnt_q;
	logic [COUNT_BITS-1:0]     sec_cnt_q;

	logic                      out_valid_q;
	logic [bar_pkg::PAD_W-1:0] press_q;
	logic [bar_pkg::PAD_W-1:0] now_q;
	logic [bar_pkg::PAD_W-1:0] before_q;

	logic                      out_free;
	logic                      adv_s1;
	logic                      in_acc;

	logic                      clr;
	logic [COUNT_BITS-1:0]     h0, r0, s0, h1, r1, s1;
	logic [COUNT_BITS-1:0]     hold_n, rpt_n, sec_n;
	logic [bar_pkg::PAD_W-1:0] press_n;
	logic [CMP_W-1:0]          h1_x, r1_x, s1_x, dly_x, rp_x, sp_x;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
		sat_inc = (&c) ? c : c + COUNT_BITS'(1);
	endfunction

	assign out_free  = !out_valid_q || !out_stall;
	assign adv_s1    = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_comb begin
		clr = (pad_s1 == '0) || hold_s1;
		h0 = clr ? '0 : hold_cnt_q;
		r0 = clr ? '0 : rpt_cnt_q;
		s0 = clr ? '0 : sec_cnt_q;
		h1 = sat_inc(h0);
		r1 = sat_inc(r0);
		s1 = sat_inc(s0);
		h1_x  = CMP_W'(h1);
		r1_x  = CMP_W'(r1);
		s1_x  = CMP_W'(s1);
		dly_x = CMP_W'(init_delay_q);
		rp_x  = CMP_W'(rpt_period_q);
		sp_x  = CMP_W'(sec_period_q);
		press_n = '0;
		hold_n  = h0;
		rpt_n   = r0;
		sec_n   = s0;
		if ((last_q != pad_s1) || ((pad_s1 & bar_pkg::BTN_RPT) == '0)) begin
			press_n = ~last_q & pad_s1;
			hold_n  = '0;
		end else begin
			hold_n = h1;
			if (h1_x == dly_x) begin
				press_n = pad_s1 & bar_pkg::BTN_RPT;
			end
			if (h1_x >= dly_x) begin
				rpt_n = r1;
				sec_n = s1;
				if (r1_x >= rp_x) begin
					rpt_n = '0;
					if ((pad_s1 & bar_pkg::BTN_SQUARE) != '0) begin
						press_n = pad_s1 & bar_pkg::BTN_LR;
					end else begin
						press_n = pad_s1 & bar_pkg::BTN_DPAD;
					end
				end
				if (s1_x >= sp_x) begin
					sec_n = '0;
					if ((pad_s1 & bar_pkg::BTN_SQUARE) != '0) begin
						press_n = press_n | (pad_s1 & (bar_pkg::BTN_SHLD | bar_pkg::BTN_UPDOWN));
					end else begin
						press_n = press_n | (pad_s1 & bar_pkg::BTN_SHLD);
					end
				end
			end else begin
				rpt_n = '0;
				sec_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_delay_q <= bar_pkg::INIT_DELAY_RST;
			rpt_period_q <= bar_pkg::RPT_PERIOD_RST;
			sec_period_q <= bar_pkg::SEC_PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bar_pkg::REG_INIT_DELAY: init_delay_q <= cfg_data;
				bar_pkg::REG_RPT_PERIOD: rpt_period_q <= cfg_data;
				bar_pkg::REG_SEC_PERIOD: sec_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			last_q      <= '0;
			hold_cnt_q  <= '0;
			rpt_cnt_q   <= '0;
			sec_cnt_q   <= '0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
			if (adv_s1) begin
				last_q     <= pad_s1;
				hold_cnt_q <= hold_n;
				rpt_cnt_q  <= rpt_n;
				sec_cnt_q  <= sec_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pad_s1  <= pad_bits;
			hold_s1 <= counters_hold;
		end
		if (adv_s1) begin
			press_q  <= press_n;
			now_q    <= pad_s1;
			before_q <= last_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign new_press   = press_q;
	assign held_now    = now_q;
	assign held_before = before_q;

endmodule

`default_nettype wire
